// ===== rtl/core/acrms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_pkg
// shared widths, register indexes, job, divider and sequencer state types for the rms meter
// ----------------------------------------------------------------------------
package acrms_pkg;

	// item fields
	localparam int MV_W        = 12;
	localparam int MA_W        = 16;

	// window accumulators
	localparam int SUM_W       = 28;
	localparam int SQ_W        = 40;
	localparam int MAX_SAMPLES = 65536;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

	// configuration registers
	localparam int SLOPE_W     = 24;
	localparam int OFFS_W      = 17;
	localparam int FLOOR_W     = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = CFG_IDX_W'(2);
	localparam logic [SLOPE_W-1:0]   SLOPE_RST  = SLOPE_W'(65536);

	// job queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// back end arithmetic
	localparam int MUL_SPLIT   = 20;
	localparam int HI_W        = SQ_W - MUL_SPLIT;
	localparam int DIVD_W      = CNT_W + SQ_W;
	localparam int DIVS_W      = CNT_W;
	localparam int DCNT_W      = $clog2(DIVD_W);
	localparam int FRAC_W      = 16;
	localparam int VAR_W       = 40;
	localparam int ROOT_W      = VAR_W / 2;
	localparam int SQ_STEPS    = VAR_W / 2;
	localparam int SCNT_W      = $clog2(SQ_STEPS);
	localparam int RND_SH      = 24;
	localparam int PROD_W      = SLOPE_W + ROOT_W;
	localparam int SCALED_W    = PROD_W - RND_SH;
	localparam int MA_SUM_W    = SCALED_W + 2;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
		logic [CNT_W-1:0] cnt;
	} job_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MUL_LO,
		B_MUL_HI,
		B_SQR,
		B_SUB,
		B_DIV1,
		B_DIV2,
		B_SQRT,
		B_SCALE,
		B_FINAL
	} back_state_t;

endpackage

// ===== rtl/core/acrms_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms channel interfaces
// valid/ready channels for samples in and window results out
// ----------------------------------------------------------------------------
interface acrms_sample_if;
	import acrms_pkg::*;

	logic            valid;
	logic            ready;
	logic [MV_W-1:0] sample_mv;
	logic            sample_ok;
	logic            window_end;

	modport source (output valid, output sample_mv, output sample_ok, output window_end,
		input ready);
	modport sink (input valid, input sample_mv, input sample_ok, input window_end,
		output ready);
endinterface

interface acrms_result_if;
	import acrms_pkg::*;

	logic            valid;
	logic            ready;
	logic [MA_W-1:0] current_ma;
	logic            no_reading;

	modport source (output valid, output current_ma, output no_reading, input ready);
	modport sink (input valid, input current_ma, input no_reading, output ready);
endinterface

// ===== rtl/core/acrms_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_front
// accumulates sum, sum of squares and count; hands a job over at window end
// ----------------------------------------------------------------------------
module acrms_front (
	input  logic            clk,
	input  logic            arst_n,
	acrms_sample_if.sink    smp,
	input  logic            q_full,
	output logic            q_push,
	output acrms_pkg::job_t q_data
);
	import acrms_pkg::*;

	logic [SUM_W-1:0]   sum_q, sum_nx;
	logic [SQ_W-1:0]    sq_q, sq_nx;
	logic [CNT_W-1:0]   cnt_q, cnt_nx;
	logic [2*MV_W-1:0]  mv_sq;
	logic               take;
	logic               add;

	assign smp.ready = !q_full;
	assign take      = smp.valid && smp.ready;
	assign add       = smp.sample_ok && (cnt_q < CNT_W'(MAX_SAMPLES));
	assign mv_sq     = (2*MV_W)'(smp.sample_mv) * (2*MV_W)'(smp.sample_mv);

	always_comb begin
		sum_nx = sum_q;
		sq_nx  = sq_q;
		cnt_nx = cnt_q;
		if (add) begin
			sum_nx = sum_q + SUM_W'(smp.sample_mv);
			sq_nx  = sq_q + SQ_W'(mv_sq);
			cnt_nx = cnt_q + 1'b1;
		end
	end

	// closing request carries its own sample
	assign q_push     = take && smp.window_end;
	assign q_data.sum = sum_nx;
	assign q_data.sq  = sq_nx;
	assign q_data.cnt = cnt_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q  <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (smp.window_end) begin
				sum_q <= '0;
				sq_q  <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nx;
				sq_q  <= sq_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

endmodule

// ===== rtl/core/acrms_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_queue
// short job queue between the accumulating front and the math back end
// ----------------------------------------------------------------------------
module acrms_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  acrms_pkg::job_t wdata,
	output logic            full,
	input  logic            pop,
	output acrms_pkg::job_t rdata,
	output logic            empty
);
	import acrms_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/acrms_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module acrms_div (
	input  logic                clk,
	input  logic                arst_n,
	input  acrms_pkg::div_req_t req,
	output acrms_pkg::div_rsp_t rsp
);
	import acrms_pkg::*;

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] den_q;
	logic [DCNT_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W:0]   rem_sh;
	logic [DIVS_W:0]   diff;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[DIVD_W-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});
	assign diff   = rem_sh - {1'b0, den_q};

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == DCNT_W'(DIVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], ge};
			rem_q <= ge ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
		end
	end

endmodule

// ===== rtl/core/acrms_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_back
// per-window sequencer: variance, square root, scaling and result register
// ----------------------------------------------------------------------------
module acrms_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  acrms_pkg::job_t             q_data,
	input  logic                        q_empty,
	output logic                        q_pop,
	output acrms_pkg::div_req_t         div_req,
	input  acrms_pkg::div_rsp_t         div_rsp,
	input  logic [acrms_pkg::SLOPE_W-1:0] slope_q16,
	input  logic signed [acrms_pkg::OFFS_W-1:0] offset_ma,
	input  logic [acrms_pkg::FLOOR_W-1:0] noise_floor_ma,
	acrms_result_if.source              res
);
	import acrms_pkg::*;

	back_state_t state_q, state_nx;

	job_t                       job_q;
	logic                       empty_q;
	logic [CNT_W+MUL_SPLIT-1:0] prod_q;
	logic [CNT_W+HI_W-1:0]      mul_hi;
	logic [DIVD_W-1:0]          a_q;
	logic [2*SUM_W-1:0]         b_q;
	logic [DIVD_W-1:0]          num;
	logic [VAR_W-1:0]           rem_q, root_q, bit_q, trial;
	logic [SCNT_W-1:0]          step_q;
	logic [PROD_W-1:0]          prod_sc;
	logic [SCALED_W-1:0]        scaled_q;
	logic signed [MA_SUM_W-1:0] ma;
	logic [MA_W-1:0]            ma_sat;
	logic                       res_valid_q;
	logic [MA_W-1:0]            cur_q;
	logic                       nord_q;
	logic                       res_load;

	assign mul_hi  = (CNT_W+HI_W)'(job_q.cnt) * (CNT_W+HI_W)'(job_q.sq[SQ_W-1:MUL_SPLIT]);
	assign num     = (a_q > DIVD_W'(b_q)) ? (a_q - DIVD_W'(b_q)) : '0;
	assign trial   = root_q + bit_q;
	assign prod_sc = PROD_W'(slope_q16) * PROD_W'(root_q[ROOT_W-1:0])
		+ (PROD_W'(1) << (RND_SH - 1));

	// signed sum, then floor and saturate
	always_comb begin
		ma = $signed({2'b00, scaled_q}) + MA_SUM_W'(offset_ma);
		if (ma < $signed({(MA_SUM_W-FLOOR_W)'(0), noise_floor_ma})) begin
			ma_sat = '0;
		end else if (ma > $signed(MA_SUM_W'({MA_W{1'b1}}))) begin
			ma_sat = '1;
		end else begin
			ma_sat = ma[MA_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					state_nx = (q_data.cnt == '0) ? B_FINAL : B_MUL_LO;
				end
			end
			B_MUL_LO: state_nx = B_MUL_HI;
			B_MUL_HI: state_nx = B_SQR;
			B_SQR:    state_nx = B_SUB;
			B_SUB:    state_nx = B_DIV1;
			B_DIV1: begin
				if (div_rsp.done) begin
					state_nx = B_DIV2;
				end
			end
			B_DIV2: begin
				if (div_rsp.done) begin
					state_nx = B_SQRT;
				end
			end
			B_SQRT: begin
				if (step_q == SCNT_W'(SQ_STEPS - 1)) begin
					state_nx = B_SCALE;
				end
			end
			B_SCALE: state_nx = B_FINAL;
			B_FINAL: begin
				if (res_load) begin
					state_nx = B_IDLE;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop            = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = num;
		div_req.divisor  = job_q.cnt;
		res_load         = 1'b0;
		case (state_q)
			B_IDLE:  q_pop = !q_empty;
			B_SUB:   div_req.start = 1'b1;
			B_DIV1: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {div_rsp.quotient[DIVD_W-FRAC_W-1:0], FRAC_W'(0)};
			end
			B_FINAL: res_load = !res_valid_q || res.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					job_q   <= q_data;
					empty_q <= (q_data.cnt == '0);
				end
			end
			B_MUL_LO: prod_q <= (CNT_W+MUL_SPLIT)'(job_q.cnt)
				* (CNT_W+MUL_SPLIT)'(job_q.sq[MUL_SPLIT-1:0]);
			B_MUL_HI: a_q <= DIVD_W'(prod_q) + (DIVD_W'(mul_hi) << MUL_SPLIT);
			B_SQR:    b_q <= (2*SUM_W)'(job_q.sum) * (2*SUM_W)'(job_q.sum);
			B_DIV2: begin
				if (div_rsp.done) begin
					rem_q  <= div_rsp.quotient[VAR_W-1:0];
					root_q <= '0;
					bit_q  <= VAR_W'(1) << (VAR_W - 2);
					step_q <= '0;
				end
			end
			B_SQRT: begin
				if (rem_q >= trial) begin
					rem_q  <= rem_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				step_q <= step_q + 1'b1;
			end
			B_SCALE: scaled_q <= prod_sc[PROD_W-1:RND_SH];
			B_FINAL: begin
				if (res_load) begin
					cur_q  <= empty_q ? '0 : ma_sat;
					nord_q <= empty_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid      = res_valid_q;
	assign res.current_ma = cur_q;
	assign res.no_reading = nord_q;

endmodule

// ===== rtl/core/ac_rms_current_meter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac_rms_current_meter_top
// true rms ac current from clamp voltage samples, one result per window
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake        payload
//  smp       in         valid / ready    sample_mv[11:0], sample_ok, window_end
//  res       out        valid / ready    current_ma[15:0], no_reading
//  cfg       in         cfg_we           cfg_index[1:0], cfg_data[23:0]
//
//  the front takes one sample request per cycle; its adders close a window in
//  the cycle of its last sample and queue the totals (two windows deep)
//  the back handles one window at a time, using the shared divider
//  (two 57-step divisions) and the 20-step square root
//  samples stall only when both queue slots hold windows not yet processed
//  asynchronous active-low reset clears accumulators, queue, sequencer and
//  restores slope 1.0, offset 0 and noise floor 0
//
module ac_rms_current_meter_top (
	input  logic                              clk,
	input  logic                              arst_n,
	acrms_sample_if.sink                      smp,
	acrms_result_if.source                    res,
	input  logic                              cfg_we,
	input  logic [acrms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [acrms_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import acrms_pkg::*;

	// calibration registers
	logic [SLOPE_W-1:0]        slope_q;
	logic signed [OFFS_W-1:0]  offset_q;
	logic [FLOOR_W-1:0]        floor_q;

	// front to queue to back
	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	job_t      q_wdata;
	job_t      q_rdata;

	// back to divider
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	// writes to an unused index fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q  <= SLOPE_RST;
			offset_q <= '0;
			floor_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOPE:  slope_q  <= cfg_data[SLOPE_W-1:0];
				REG_OFFSET: offset_q <= $signed(cfg_data[OFFS_W-1:0]);
				REG_FLOOR:  floor_q  <= cfg_data[FLOOR_W-1:0];
				default: ;
			endcase
		end
	end

	// accumulate samples, emit window totals
	acrms_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	// decouples sample intake from the long per-window math
	acrms_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// shared divider for both variance divisions
	acrms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// variance, root, calibration, output register
	acrms_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_data         (q_rdata),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.div_req        (div_req),
		.div_rsp        (div_rsp),
		.slope_q16      (slope_q),
		.offset_ma      (offset_q),
		.noise_floor_ma (floor_q),
		.res            (res)
	);

	// an empty window always reports zero current
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.no_reading) |-> (res.current_ma == '0))
		else $error("no_reading result with nonzero current");

	// back end never pulls from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue pop while empty");

	// a closed window is waiting in the queue in the next cycle
	a_window_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(smp.valid && smp.ready && smp.window_end) |=> !q_empty)
		else $error("window end request not queued");

endmodule
